// ===== rtl/ascii_number_parser_u32_unit_assert.svh =====
// assertion macros used by the checker file of the ascii number parser
// depends on nothing; the including module must have clk and rst_n in scope
`ifndef ASCII_NUMBER_PARSER_U32_UNIT_ASSERT_SVH
`define ASCII_NUMBER_PARSER_U32_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ANPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define ANPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/anpu_pkg.sv =====
// shared types, constants and the digit decoder of the ascii number parser
// depends on nothing
`timescale 1ns / 1ps

package anpu_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 5;
    // product width: value times 16 plus a digit always fits
    localparam int unsigned PROD_W  = VALUE_W + 4;

    localparam logic [CHAR_W-1:0]  CHAR_TERM   = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_X = 8'h58;
    localparam logic [DIGIT_W-1:0] BASE_DEC    = 5'd10;
    localparam logic [DIGIT_W-1:0] BASE_HEX    = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 5'd16;

    // result of one step, seen by the output stage
    typedef struct packed {
        logic                term;
        logic                ok;
        logic [VALUE_W-1:0]  value;
    } result_t;

    // digit value 0..15, or DIGIT_NONE for a byte that is no digit
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        off = '0;
        if (c inside {[8'h30:8'h39]})
        begin
            off = c - 8'h30;
            return off[DIGIT_W-1:0];
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            off = c - 8'h57;
            return off[DIGIT_W-1:0];
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            off = c - 8'h37;
            return off[DIGIT_W-1:0];
        end
        return DIGIT_NONE;
    endfunction

endpackage

// ===== rtl/ascii_number_parser_u32_unit.sv =====
// top level of the streaming ascii to 32-bit unsigned parser
// depends on anpu_pkg and anpu_step
`timescale 1ns / 1ps

// Usage:
//   Input channel: one ASCII byte per item on char_code with in_valid; the
//   item is taken at a rising edge with in_valid high and in_stall low.
//   A zero byte ends the number; every other byte yields no result.
//   Output channel: one item per terminator, ok and value with out_valid,
//   taken at a rising edge with out_valid high and out_stall low.
//   A terminator passes through the input register, then the output register.
//   Throughput: one item per cycle unless stalled; the parse state is
//   updated by one shift-add and compare between input register and state.
//   When the receiver stalls, the result holds in the output register and
//   the input keeps flowing until a second terminator has to wait behind
//   it; in_stall then rises and holds that terminator in the input register.
//   Reset clears the valid flags of both registers and returns the parser
//   to the start of a number in decimal mode with no error.
module ascii_number_parser_u32_unit
    import anpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CHAR_W-1:0]  char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [VALUE_W-1:0] value
);

    logic               s1_valid_reg;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               out_free;
    logic               adv;
    result_t            res;

    anpu_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (adv),
        .char_code (s1_char_reg),
        .res       (res)
    );

    // stage control: only a terminator needs room in the output register
    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        adv            = s1_valid_reg && (!res.term || out_free);
        in_stall       = s1_valid_reg && !adv;
        out_valid_next = out_free ? (adv && res.term) : out_valid_reg;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_char_reg <= char_code;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && adv && res.term)
        begin
            ok_reg    <= res.ok;
            value_reg <= res.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign value     = value_reg;

endmodule

// ===== rtl/anpu_step.sv =====
// parser state and the per-character update: prefix, digit check, shift-add
// depends on anpu_pkg
`timescale 1ns / 1ps

module anpu_step
    import anpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [CHAR_W-1:0]  char_code,
    output result_t            res
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [1:0]         pos_reg, pos_next;
    logic               hex_reg, hex_next;
    logic               await_reg, await_next;
    logic               fail_reg, fail_next;

    logic               is_term;
    logic               is_prefix;
    logic [DIGIT_W-1:0] digit;
    logic               digit_bad;
    logic [PROD_W-1:0]  acc_wide;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  sum;
    logic               ovf;
    logic               ok_now;

    // decode the character against the current state
    always_comb
    begin
        is_term   = (char_code == CHAR_TERM);
        is_prefix = (pos_reg == 2'd1) && !hex_reg && (acc_reg == '0) &&
                    ((char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X));
        digit     = digit_of(char_code);
        digit_bad = digit >= (hex_reg ? BASE_HEX : BASE_DEC);
    end

    // times 16 is a shift, times 10 is two shifts and an add
    always_comb
    begin
        acc_wide = {{(PROD_W-VALUE_W){1'b0}}, acc_reg};
        if (hex_reg)
        begin
            prod = acc_wide << 4;
        end
        else
        begin
            prod = (acc_wide << 3) + (acc_wide << 1);
        end
        sum = prod + {{(PROD_W-DIGIT_W){1'b0}}, digit};
        ovf = |sum[PROD_W-1:VALUE_W];
    end

    // next state
    always_comb
    begin
        acc_next   = acc_reg;
        pos_next   = (pos_reg == 2'd2) ? pos_reg : pos_reg + 2'd1;
        hex_next   = hex_reg;
        await_next = await_reg;
        fail_next  = fail_reg;
        if (is_term)
        begin
            acc_next   = '0;
            pos_next   = '0;
            hex_next   = 1'b0;
            await_next = 1'b0;
            fail_next  = 1'b0;
        end
        else if (!fail_reg)
        begin
            if (is_prefix)
            begin
                hex_next   = 1'b1;
                await_next = 1'b1;
            end
            else if (digit_bad || ovf)
            begin
                fail_next = 1'b1;
            end
            else
            begin
                acc_next   = sum[VALUE_W-1:0];
                await_next = 1'b0;
            end
        end
    end

    // result seen when the terminator arrives
    always_comb
    begin
        ok_now    = !fail_reg && (pos_reg != 2'd0) && !await_reg;
        res.term  = is_term;
        res.ok    = ok_now;
        res.value = ok_now ? acc_reg : '0;
    end

    // state registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pos_reg   <= '0;
            hex_reg   <= 1'b0;
            await_reg <= 1'b0;
            fail_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            hex_reg   <= hex_next;
            await_reg <= await_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

// ===== rtl/anpu_checker.sv =====
// port-level checks for the ascii number parser, bound to the top level
// depends on anpu_pkg and ascii_number_parser_u32_unit_assert.svh
`timescale 1ns / 1ps
`include "ascii_number_parser_u32_unit_assert.svh"

module anpu_checker
    import anpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               ok,
    input  logic [VALUE_W-1:0] value
);

    logic               in_held;
    logic               out_held;
    logic [VALUE_W:0]   res_bits;

    // items waiting on each side and the result seen as one word
    assign in_held  = in_valid && in_stall;
    assign out_held = out_valid && out_stall;
    assign res_bits = {ok, value};

    // a failed parse always reports a zero value
    `ANPU_ASSERT_NOW(a_fail_value_zero, out_valid && !ok, value == '0, "failed with value")

    // with the output register empty the input never waits
    `ANPU_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall, "stall with empty output")

    // a stalled result holds
    `ANPU_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(res_bits), "result changed")

    // a stalled input item holds
    `ANPU_ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(char_code), "input changed")

endmodule

bind ascii_number_parser_u32_unit anpu_checker u_anpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .value     (value)
);
